### hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// shared widths, register indexes and reset values of the 3x3 lbp encoder
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PIXEL_W           = 8;
   localparam int CODE_W            = 8;
   localparam int CFG_W             = 12;
   localparam int ROW_W             = 12;
   localparam int CSR_INDEX_W       = 1;
   localparam int DEFAULT_MAX_WIDTH = 2048;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
   localparam logic [CFG_W-1:0] MIN_DIM      = CFG_W'(3);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

endpackage

### hw/rtl/lbp_3x3_encoder_top.sv
// ----------------------------------------------------------------------------
// lbp_3x3_encoder_top
// 3x3 local binary pattern encoder for a raster-order grey pixel stream
// ----------------------------------------------------------------------------
// timing: a code reaches rsp_tvalid from the output register, which loads as
//    stage 1 retires the pixel completing its window
// throughput: one pixel per clock while rsp_tready does not stall, set by the
//    line memory: one read (at accept), one write-back (as stage 1 retires)
// reset: counters, window and size registers (640 x 480) clear at once; the
//    line memory is not cleared, no clearing pass, words accepted right away
module lbp_3x3_encoder_top #(
   parameter int MAX_WIDTH = lbp_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lbp_pkg::PIXEL_W-1:0]         req_tdata,   // [7:0] pixel
   // code output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lbp_pkg::CODE_W-1:0]          rsp_tdata,   // [7:0] pattern_code
   output logic                                rsp_tlast,   // frame_end
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lbp_pkg::CFG_W-1:0]           csr_data
);

   localparam int PW = lbp_pkg::PIXEL_W;
   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   // compare width that holds the column bound and the width register
   localparam int EW = ($clog2(MAX_WIDTH + 1) > lbp_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : lbp_pkg::CFG_W;
   localparam int RW = lbp_pkg::ROW_W;

   // size registers
   logic [lbp_pkg::CFG_W-1:0] width_ff;
   logic [lbp_pkg::CFG_W-1:0] height_ff;

   // raster position of the next pixel
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // line memory: each word holds {upper line pixel, middle line pixel}
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_ff;

   // stage 1: pixel whose line-memory read is in flight
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic [PW-1:0] s1_pixel_ff;

   // window: [0..1] top c-2,c-1  [2..3] middle  [4..5] bottom
   logic [PW-1:0] win_ff [6];

   // output register
   logic                        rsp_valid_ff;
   logic [lbp_pkg::CODE_W-1:0]  rsp_code_ff;
   logic                        rsp_last_ff;

   logic          accept;
   logic          s1_go;
   logic [EW-1:0] width_ext;
   logic [EW-1:0] eff_width;
   logic [RW-1:0] eff_height;
   logic [EW-1:0] col_inc;
   logic [RW:0]   row_inc;
   logic          col_last;
   logic          row_last;
   logic          emit;
   logic [PW-1:0] up_px;
   logic [PW-1:0] mid_px;
   logic [PW-1:0] centre;
   logic [lbp_pkg::CODE_W-1:0] code;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lbp_pkg::WIDTH_RESET;
         height_ff <= lbp_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lbp_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            lbp_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective sizes: width clamped to 3..MAX_WIDTH, height raised to 3
   assign width_ext = EW'(width_ff);

   always_comb begin
      priority if (width_ext < EW'(lbp_pkg::MIN_DIM)) begin
         eff_width = EW'(lbp_pkg::MIN_DIM);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
   end

   assign eff_height = (height_ff < lbp_pkg::MIN_DIM) ? RW'(lbp_pkg::MIN_DIM) : height_ff;

   // ------------------------------------------------------------------------
   // handshake: stage 1 drains into the output register, or simply retires
   // when its pixel makes no code
   // ------------------------------------------------------------------------
   assign s1_go      = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // raster counters, evaluated for the word being accepted
   // ------------------------------------------------------------------------
   assign col_inc  = EW'(col_ff) + EW'(1);
   assign row_inc  = {1'b0, row_ff} + (RW+1)'(1);
   assign col_last = (col_inc >= eff_width);
   assign row_last = (row_inc >= {1'b0, eff_height});
   assign emit     = (row_ff >= RW'(2)) && (col_ff >= CW'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_inc[RW-1:0];
      end else begin
         col_in = col_inc[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // line memory: read at accept, write back when stage 1 retires; the next
   // read is always at another column (width is at least 3), so no bypass
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_col_ff] <= {mid_px, s1_pixel_ff};
      end
   end

   assign up_px  = rd_ff[2*PW-1:PW];
   assign mid_px = rd_ff[PW-1:0];

   // ------------------------------------------------------------------------
   // stage 1 control and payload
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_ff;
         s1_emit_ff  <= emit;
         s1_last_ff  <= col_last && row_last;
         s1_pixel_ff <= req_tdata;
      end
   end

   // ------------------------------------------------------------------------
   // pattern: neighbor >= center, bit 7 top-left going clockwise
   // ------------------------------------------------------------------------
   assign centre = win_ff[3];

   always_comb begin
      code[7] = (win_ff[0]   >= centre);
      code[6] = (win_ff[1]   >= centre);
      code[5] = (up_px       >= centre);
      code[4] = (mid_px      >= centre);
      code[3] = (s1_pixel_ff >= centre);
      code[2] = (win_ff[5]   >= centre);
      code[1] = (win_ff[4]   >= centre);
      code[0] = (win_ff[2]   >= centre);
   end

   // window shifts one column left as stage 1 retires
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= up_px;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_px;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_pixel_ff;
      end
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_code_ff <= code;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a new read never hits the column being written back
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_go) |-> (col_ff != s1_col_ff))
      else $error("line memory read and write-back at the same column");

   // a stalled stage 1 keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_col_ff)
                                   && $stable(s1_pixel_ff) && $stable(rd_ff)))
      else $error("stage 1 lost its word while stalled");

   // a code appears only from a retiring stage 1 that makes one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_emit_ff))
      else $error("output word without a producing stage 1 word");

   // output register is never overwritten while its code waits
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_go && s1_emit_ff))
      else $error("pending code overwritten");
`endif

endmodule
